// File: src/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg: shared definitions for the motor position P controller
// Drive direction codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mpc_pkg;

   // Field widths.
   localparam int unsigned CountWidth    = 16;
   localparam int unsigned PosWidth      = 32;
   localparam int unsigned GainWidth     = 4;
   localparam int unsigned DutyWidth     = 8;
   localparam int unsigned DirWidth      = 2;
   localparam int unsigned CsrIndexWidth = 8;
   localparam int unsigned CsrDataWidth  = 8;

   // The error carries one extra bit, the product adds the gain width plus sign.
   localparam int unsigned ErrWidth  = PosWidth + 1;
   localparam int unsigned ProdWidth = ErrWidth + GainWidth + 1;
   localparam int unsigned MagWidth  = ProdWidth - 1;

   typedef logic [DirWidth-1:0]      dir_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   // Bridge drive codes.
   localparam dir_type DIR_COAST   = 2'd0;
   localparam dir_type DIR_FORWARD = 2'd1;
   localparam dir_type DIR_REVERSE = 2'd2;

   // Register indexes on the configuration port.
   localparam csr_index_type CSR_GAIN          = 8'd0;
   localparam csr_index_type CSR_PWM_MAX       = 8'd1;
   localparam csr_index_type CSR_PWM_MIN       = 8'd2;
   localparam csr_index_type CSR_UPDATE_PERIOD = 8'd3;

   // Register reset values.
   localparam logic [GainWidth-1:0] GAIN_RESET          = 4'd2;
   localparam logic [DutyWidth-1:0] PWM_MAX_RESET       = 8'd254;
   localparam logic [DutyWidth-1:0] PWM_MIN_RESET       = 8'd60;
   localparam logic [7:0]           UPDATE_PERIOD_RESET = 8'd10;

endpackage

`default_nettype wire

// File: src/motor_position_p_controller.sv
// ----------------------------------------------------------------------------
// motor_position_p_controller: proportional position loop for a DC motor
// Tracks encoder position, runs a clamped P controller every few ticks.
// ----------------------------------------------------------------------------
// Usage: each beat on the req_ channel is one timer tick, carrying the
// encoder pulses counted since the previous tick and the target position.
// Every tick produces exactly one beat on the rsp_ channel with the drive
// direction and duty in force after the tick, a flag telling whether the
// controller ran, and the accumulated position.
// The request is captured in an input register; once the result side is free,
// one combinational pass (position accumulate, error, multiply by the 4-bit gain,
// clamp) loads the result register, which drives the response beat. One tick
// is accepted every cycle as long as the receiver keeps taking responses.
// When the receiver stalls, the response register holds and the input
// register can still take one more tick; after that req_ready drops until
// the response is taken. No tick is lost or repeated.
// The csr_ channel is always ready; write it only while no tick is in flight.
// Synchronous reset clears the position, the tick counter and the drive
// (coast, duty zero), and loads the register defaults: gain 2, maximum duty
// 254, minimum duty 60, update period 10.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_position_p_controller (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // Tick requests.
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic [mpc_pkg::CountWidth-1:0]           req_encoder_count,
   input  wire logic signed [mpc_pkg::PosWidth-1:0]      req_target_position,
   // Responses.
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic [mpc_pkg::DirWidth-1:0]                  rsp_direction,
   output logic [mpc_pkg::DutyWidth-1:0]                 rsp_duty,
   output logic                                          rsp_updated,
   output logic signed [mpc_pkg::PosWidth-1:0]           rsp_position_now,
   // Register writes.
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [mpc_pkg::CsrIndexWidth-1:0]        csr_index,
   input  wire logic [mpc_pkg::CsrDataWidth-1:0]         csr_data
);

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [mpc_pkg::GainWidth-1:0] gain_ff;
   logic [mpc_pkg::DutyWidth-1:0] pwm_max_ff;
   logic [mpc_pkg::DutyWidth-1:0] pwm_min_ff;
   logic [7:0]                    period_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= mpc_pkg::GAIN_RESET;
         pwm_max_ff <= mpc_pkg::PWM_MAX_RESET;
         pwm_min_ff <= mpc_pkg::PWM_MIN_RESET;
         period_ff  <= mpc_pkg::UPDATE_PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mpc_pkg::CSR_GAIN:          gain_ff    <= csr_data[mpc_pkg::GainWidth-1:0];
            mpc_pkg::CSR_PWM_MAX:       pwm_max_ff <= csr_data;
            mpc_pkg::CSR_PWM_MIN:       pwm_min_ff <= csr_data;
            mpc_pkg::CSR_UPDATE_PERIOD: period_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register. It refills whenever its beat moves on to the result
   // register, so a tick can be taken every cycle while the result side is free.
   // ---------------------------------------------------------------------
   logic                                in_valid_ff;
   logic [mpc_pkg::CountWidth-1:0]      count_ff;
   logic signed [mpc_pkg::PosWidth-1:0] target_ff;
   logic                                out_free;
   logic                                advance;

   assign out_free  = !rsp_valid || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         count_ff  <= req_encoder_count;
         target_ff <= req_target_position;
      end
   end

   // ---------------------------------------------------------------------
   // Controller state.
   // ---------------------------------------------------------------------
   logic signed [mpc_pkg::PosWidth-1:0] position_ff;
   logic signed [mpc_pkg::PosWidth-1:0] position_in;
   logic [7:0]                          tick_ff;
   logic [7:0]                          tick_in;
   logic [mpc_pkg::DirWidth-1:0]        drive_dir_ff;
   logic [mpc_pkg::DirWidth-1:0]        drive_dir_in;
   logic [mpc_pkg::DutyWidth-1:0]       drive_duty_ff;
   logic [mpc_pkg::DutyWidth-1:0]       drive_duty_in;
   logic                                run;

   // Single pass datapath.
   logic [mpc_pkg::PosWidth-1:0]         count_ext;
   logic [7:0]                           tick_inc;
   logic signed [mpc_pkg::ErrWidth-1:0]  error;
   logic signed [mpc_pkg::ProdWidth-1:0] product;
   logic [mpc_pkg::MagWidth-1:0]         magnitude;
   logic                                 over_max;
   logic [mpc_pkg::DutyWidth-1:0]        clamped;
   logic [mpc_pkg::DutyWidth-1:0]        duty_new;

   always_comb begin
      count_ext = {{(mpc_pkg::PosWidth-mpc_pkg::CountWidth){1'b0}}, count_ff};

      // The position moves with the drive that was in force before this tick.
      case (drive_dir_ff)
         mpc_pkg::DIR_FORWARD: position_in = position_ff - $signed(count_ext);
         mpc_pkg::DIR_REVERSE: position_in = position_ff + $signed(count_ext);
         default:              position_in = position_ff;
      endcase

      tick_inc = tick_ff + 8'd1;
      run      = (tick_inc == period_ff);
      tick_in  = run ? 8'd0 : tick_inc;

      // Exact error and product, so a huge error saturates with its true sign.
      error   = mpc_pkg::ErrWidth'(position_in) - mpc_pkg::ErrWidth'(target_ff);
      product = mpc_pkg::ProdWidth'(error)
              * $signed({{(mpc_pkg::ProdWidth-mpc_pkg::GainWidth){1'b0}}, gain_ff});
      magnitude = product[mpc_pkg::ProdWidth-1]
                ? mpc_pkg::MagWidth'(-product)
                : mpc_pkg::MagWidth'(product);

      over_max = (magnitude[mpc_pkg::MagWidth-1:mpc_pkg::DutyWidth] != '0)
              || (magnitude[mpc_pkg::DutyWidth-1:0] > pwm_max_ff);
      clamped  = over_max ? pwm_max_ff : magnitude[mpc_pkg::DutyWidth-1:0];

      // A nonzero duty below the minimum is raised, even above the maximum.
      if ((clamped != '0) && (clamped < pwm_min_ff)) begin
         duty_new = pwm_min_ff;
      end else begin
         duty_new = clamped;
      end

      drive_dir_in  = drive_dir_ff;
      drive_duty_in = drive_duty_ff;
      if (run) begin
         if (duty_new == '0) begin
            drive_dir_in  = mpc_pkg::DIR_COAST;
            drive_duty_in = '0;
         end else begin
            drive_dir_in  = product[mpc_pkg::ProdWidth-1] ? mpc_pkg::DIR_REVERSE
                                                          : mpc_pkg::DIR_FORWARD;
            drive_duty_in = duty_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         tick_ff       <= '0;
         drive_dir_ff  <= mpc_pkg::DIR_COAST;
         drive_duty_ff <= '0;
      end else if (advance) begin
         position_ff   <= position_in;
         tick_ff       <= tick_in;
         drive_dir_ff  <= drive_dir_in;
         drive_duty_ff <= drive_duty_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register.
   // ---------------------------------------------------------------------
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_direction    <= drive_dir_in;
         rsp_duty         <= drive_duty_in;
         rsp_updated      <= run;
         rsp_position_now <= position_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   // A waiting response always mirrors the drive and position just stored.
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_direction == drive_dir_ff) && (rsp_duty == drive_duty_ff)
                    && (rsp_position_now == position_ff))
      else $error("response does not match controller state");

   // Coasting always carries zero duty.
   a_coast_zero_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_direction == mpc_pkg::DIR_COAST) |-> (rsp_duty == '0))
      else $error("coast with nonzero duty");

   // A controller run restarts the tick counter.
   a_run_clears_tick: assert property (@(posedge clock) disable iff (reset)
      advance && run |=> (tick_ff == '0))
      else $error("tick counter not cleared after controller run");

   // A captured tick stays in the input register until the result side frees.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(count_ff)
                                   && $stable(target_ff))
      else $error("captured tick lost while output stalled");

endmodule

`default_nettype wire
